// ----- sv/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted min priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam int unsigned REG_KEY_SELECT = 0;

	localparam logic KEY_BY_DISTANCE = 1'b0;
	localparam logic KEY_BY_COST     = 1'b1;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} spq_cmd_t;

endpackage
`default_nettype wire

// ----- sv/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key and an identifier, keeps, takes
// the new entry, or takes a neighbor's entry on each transaction.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 16
) (
	input  wire                 clk,
	input  wire  spq_cmd_t      cmd,
	input  wire                 occupied,
	input  wire  [KEY_BITS-1:0] new_key,
	input  wire  [ID_BITS-1:0]  new_id,
	input  wire                 left_keep,
	input  wire  [KEY_BITS-1:0] left_key,
	input  wire  [ID_BITS-1:0]  left_id,
	input  wire  [KEY_BITS-1:0] right_key,
	input  wire  [ID_BITS-1:0]  right_id,
	output logic                keep,
	output logic [KEY_BITS-1:0] key,
	output logic [ID_BITS-1:0]  id
);

	logic [KEY_BITS-1:0] key_q;
	logic [ID_BITS-1:0]  id_q;

	// equal keys stay ahead of the new one, which keeps the order stable
	assign keep = occupied && (key_q <= new_key);
	assign key  = key_q;
	assign id   = id_q;

	always_ff @(posedge clk) begin
		if (cmd.push && !keep) begin
			if (left_keep) begin
				key_q <= new_key;
				id_q  <= new_id;
			end else begin
				key_q <= left_key;
				id_q  <= left_id;
			end
		end else if (cmd.pop) begin
			key_q <= right_key;
			id_q  <= right_id;
		end
	end

endmodule
`default_nettype wire

// ----- sv/sorted_min_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Stable sorted queue of edges that hands out the least key first.
// ----------------------------------------------------------------------------
// Takes one transaction (push or pop) in every clock cycle; busy stays low.
// The result appears with done in the cycle after start and lasts exactly one
// cycle, and the receiver cannot stall it. The rate comes from the chain of
// cells: every cell compares its key with the pushed key in parallel and
// shifts to its neighbor in the same cycle. key_select writes are ignored
// unless the queue is empty.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int KEY_BITS    = 32,
	parameter int ID_BITS     = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         start,
	output logic        busy,
	input  wire         mode,
	input  wire  [15:0] edge_id,
	input  wire  [31:0] distance,
	input  wire  [31:0] cost,
	output logic        done,
	output logic [15:0] popped_id,
	output logic [31:0] popped_key,
	output logic        popped_valid,
	output logic        was_empty,
	output logic        overflow,
	output logic [6:0]  fill_count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

	logic             key_select_q;
	logic [CNT_W-1:0] count_q;
	logic             accept, is_empty, is_full;
	spq_cmd_t         cmd;
	logic [KEY_BITS-1:0] new_key;
	logic [ID_BITS-1:0]  new_id;

	logic [KEY_BITS-1:0] cell_key  [QUEUE_DEPTH];
	logic [ID_BITS-1:0]  cell_id   [QUEUE_DEPTH];
	logic                cell_keep [QUEUE_DEPTH];

	// configuration port
	assign pready = 1'b1;
	assign prdata = {31'd0, key_select_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_select_q <= KEY_BY_DISTANCE;
		end else if (psel && penable && pwrite && (paddr == 2'(REG_KEY_SELECT * 4))
				&& (count_q == '0)) begin
			key_select_q <= pwdata[0];
		end
	end

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == FULL);

	assign cmd.push = accept && (mode == MODE_PUSH) && !is_full;
	assign cmd.pop  = accept && (mode == MODE_POP) && !is_empty;

	assign new_key = (key_select_q == KEY_BY_COST) ? KEY_BITS'(cost) : KEY_BITS'(distance);
	assign new_id  = ID_BITS'(edge_id);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                left_keep;
		logic [KEY_BITS-1:0] left_key, right_key;
		logic [ID_BITS-1:0]  left_id, right_id;

		if (i == 0) begin : g_head
			// front cell takes the new entry whenever it gives way
			assign left_keep = 1'b1;
			assign left_key  = '0;
			assign left_id   = '0;
		end else begin : g_body
			assign left_keep = cell_keep[i-1];
			assign left_key  = cell_key[i-1];
			assign left_id   = cell_id[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_key = '0;
			assign right_id  = '0;
		end else begin : g_mid
			assign right_key = cell_key[i+1];
			assign right_id  = cell_id[i+1];
		end

		spq_cell #(
			.KEY_BITS (KEY_BITS),
			.ID_BITS  (ID_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (IDX < count_q),
			.new_key   (new_key),
			.new_id    (new_id),
			.left_keep (left_keep),
			.left_key  (left_key),
			.left_id   (left_id),
			.right_key (right_key),
			.right_id  (right_id),
			.keep      (cell_keep[i]),
			.key       (cell_key[i]),
			.id        (cell_id[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result register
	logic             done_q;
	logic [15:0]      popped_id_q;
	logic [31:0]      popped_key_q;
	logic             popped_valid_q, was_empty_q, overflow_q;
	logic [CNT_W-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_valid_q <= cmd.pop;
			was_empty_q    <= (mode == MODE_POP) && is_empty;
			overflow_q     <= (mode == MODE_PUSH) && is_full;
			popped_id_q    <= cmd.pop ? 16'(cell_id[0]) : 16'd0;
			popped_key_q   <= cmd.pop ? 32'(cell_key[0]) : 32'd0;
			if (cmd.push) begin
				fill_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				fill_q <= count_q - 1'b1;
			end else begin
				fill_q <= count_q;
			end
		end
	end

	assign done         = done_q;
	assign popped_id    = popped_id_q;
	assign popped_key   = popped_key_q;
	assign popped_valid = popped_valid_q;
	assign was_empty    = was_empty_q;
	assign overflow     = overflow_q;
	assign fill_count   = 7'(fill_q);

endmodule
`default_nettype wire
